[rtl/core/sha1_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-1 engine package
// Shared types, constants and control structures of the SHA-1 engine.
// ----------------------------------------------------------------------------
package sha1_pkg;

	typedef logic [31:0] word_t;
	typedef logic [4:0][31:0] hash_t;

	// Initial hash values, H0 at index 0.
	localparam hash_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
		32'hEFCDAB89, 32'h67452301};

	// Round constants, one per group of twenty rounds.
	localparam logic [3:0][31:0] ROUND_K = {32'hCA62C1D6, 32'h8F1BBCDC,
		32'h6ED9EBA1, 32'h5A827999};

	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [6:0] ROUND_G1 = 7'd20;
	localparam logic [6:0] ROUND_G2 = 7'd40;
	localparam logic [6:0] ROUND_G3 = 7'd60;
	localparam logic [6:0] SCHED_SEED = 7'd16;
	localparam logic [5:0] LAST_FILL = 6'd63;
	localparam logic [5:0] LEN_FILL_LIMIT = 6'd56;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [2:0] LAST_WORD = 3'd4;

	typedef struct packed {
		logic        wr_byte;
		logic [5:0]  byte_addr;
		logic [7:0]  byte_val;
		logic        wr_len;
		logic [63:0] len;
		logic        clear;
		logic        shift;
		logic        seed;
	} sched_ctrl_t;

endpackage

[rtl/core/sha1_if.sv]
// ----------------------------------------------------------------------------
// SHA-1 engine channels
// Request channel carrying message bytes and digest channel carrying words.
// ----------------------------------------------------------------------------
interface sha1_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       message_end;

	modport source(output valid, data_byte, byte_present, message_end, input ready);
	modport sink(input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface sha1_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        final_word;

	modport source(output valid, digest_word, word_index, final_word, input ready);
	modport sink(input valid, digest_word, word_index, final_word, output ready);
endinterface

[rtl/core/sha1_sched.sv]
// ----------------------------------------------------------------------------
// SHA-1 block buffer and message schedule
// Sixteen words that collect the block bytes and then roll as the schedule.
// ----------------------------------------------------------------------------
module sha1_sched (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sha1_pkg::sched_ctrl_t ctrl,
	output sha1_pkg::word_t      w
);
	import sha1_pkg::*;

	logic [15:0][31:0] w_q;
	word_t             w_exp;
	logic [4:0]        lane_base;

	// The expansion taps sit at fixed places of the rolling window.
	assign w_exp = {w_q[13][30:0] ^ w_q[8][30:0] ^ w_q[2][30:0] ^ w_q[0][30:0],
		w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31]};
	assign w = ctrl.seed ? w_q[0] : w_exp;
	assign lane_base = {~ctrl.byte_addr[1:0], 3'b000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= '0;
		end else if (ctrl.clear) begin
			w_q <= '0;
		end else if (ctrl.shift) begin
			w_q <= {w, w_q[15:1]};
		end else begin
			if (ctrl.wr_byte) begin
				w_q[ctrl.byte_addr[5:2]][lane_base +: 8] <= ctrl.byte_val;
			end
			if (ctrl.wr_len) begin
				w_q[14] <= ctrl.len[63:32];
				w_q[15] <= ctrl.len[31:0];
			end
		end
	end

endmodule

[rtl/core/sha1_round.sv]
// ----------------------------------------------------------------------------
// SHA-1 round unit
// Working variables a to e and one compression round per step.
// ----------------------------------------------------------------------------
module sha1_round (
	input  logic            clk,
	input  logic            load,
	input  logic            step,
	input  sha1_pkg::hash_t init,
	input  sha1_pkg::word_t w,
	input  logic [6:0]      t,
	output sha1_pkg::hash_t vars
);
	import sha1_pkg::*;

	hash_t      v_q;
	word_t      a, b, c, d, e;
	word_t      f, k, tmp;

	assign a = v_q[0];
	assign b = v_q[1];
	assign c = v_q[2];
	assign d = v_q[3];
	assign e = v_q[4];
	assign vars = v_q;

	always_comb begin
		if (t < ROUND_G1) begin
			f = (b & c) | (~b & d);
			k = ROUND_K[0];
		end else if (t < ROUND_G2) begin
			f = b ^ c ^ d;
			k = ROUND_K[1];
		end else if (t < ROUND_G3) begin
			f = (b & c) | (b & d) | (c & d);
			k = ROUND_K[2];
		end else begin
			f = b ^ c ^ d;
			k = ROUND_K[3];
		end
		tmp = {a[26:0], a[31:27]} + f + e + k + w;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			v_q <= init;
		end else if (step) begin
			v_q <= {d, c, {b[1:0], b[31:2]}, a, tmp};
		end
	end

endmodule

[rtl/core/sha1_hash_engine_top.sv]
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Byte-stream SHA-1 with padding, length append and five-word digest output.
// ----------------------------------------------------------------------------
// A request whose byte does not complete a block is taken while the engine is idle.
// A request that completes a 64-byte block loads the round unit as it is taken,
// then holds the input off for 80 rounds and an add state that folds the result
// into the hash. Message end adds a padding state and one such run, or a length
// state and a second run when 56 or more bytes are held; then five digest words,
// which output stalls can hold back. Reset restores the initial hash and empties the buffer.
module sha1_hash_engine_top (
	input  logic      clk,
	input  logic      arst_n,
	sha1_in_if.sink   req,
	sha1_out_if.source rsp
);
	import sha1_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} state_t;

	state_t      state_q;
	hash_t       hash_q;
	logic [5:0]  fill_q;
	logic [63:0] bitlen_q;
	logic [6:0]  round_q;
	logic [2:0]  out_idx_q;
	logic        end_pend_q;   // message end arrived with the byte that filled a block
	logic        len_pend_q;   // length still goes into an extra all-padding block
	logic        last_q;       // block under compression is the final one

	sched_ctrl_t sched_ctrl;
	word_t       w;
	hash_t       vars;
	logic        accept;
	logic        block_full;
	logic        rnd_load;

	assign req.ready = (state_q == ST_IDLE);
	assign accept = req.valid & req.ready;
	// The byte of this request fills the last slot of the block.
	assign block_full = accept & req.byte_present & (fill_q == LAST_FILL);
	// The round unit takes the hash whenever a block run is about to start.
	assign rnd_load = block_full | (state_q == ST_PAD) | (state_q == ST_LEN);

	assign rsp.valid = (state_q == ST_OUT);
	assign rsp.digest_word = hash_q[out_idx_q];
	assign rsp.word_index = out_idx_q;
	assign rsp.final_word = (out_idx_q == LAST_WORD);

	// Buffer control. Bytes land at the fill position; padding writes the 0x80
	// marker there and, when it fits, the length words in the same cycle. The
	// buffer is cleared after each block so that the padding zeros come free.
	always_comb begin
		sched_ctrl = '0;
		sched_ctrl.byte_addr = fill_q;
		sched_ctrl.byte_val = req.data_byte;
		sched_ctrl.len = bitlen_q;
		sched_ctrl.seed = (round_q < SCHED_SEED);
		case (state_q)
			ST_IDLE: begin
				sched_ctrl.wr_byte = accept & req.byte_present;
			end
			ST_PAD: begin
				sched_ctrl.wr_byte = 1'b1;
				sched_ctrl.byte_val = PAD_BYTE;
				sched_ctrl.wr_len = (fill_q < LEN_FILL_LIMIT);
			end
			ST_LEN: begin
				sched_ctrl.wr_len = 1'b1;
			end
			ST_ROUND: begin
				sched_ctrl.shift = 1'b1;
			end
			ST_ADD: begin
				sched_ctrl.clear = 1'b1;
			end
			default: begin
			end
		endcase
	end

	sha1_sched u_sched (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (sched_ctrl),
		.w      (w)
	);

	sha1_round u_round (
		.clk  (clk),
		.load (rnd_load),
		.step (state_q == ST_ROUND),
		.init (hash_q),
		.w    (w),
		.t    (round_q),
		.vars (vars)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			hash_q     <= H_INIT;
			fill_q     <= '0;
			bitlen_q   <= '0;
			round_q    <= '0;
			out_idx_q  <= '0;
			end_pend_q <= 1'b0;
			len_pend_q <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.byte_present) begin
							fill_q   <= fill_q + 6'd1;
							bitlen_q <= bitlen_q + 64'd8;
						end
						if (block_full) begin
							end_pend_q <= req.message_end;
							state_q    <= ST_ROUND;
						end else if (req.message_end) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					end_pend_q <= 1'b0;
					// Without room for the length, an extra padding block follows.
					if (fill_q < LEN_FILL_LIMIT) begin
						last_q <= 1'b1;
					end else begin
						len_pend_q <= 1'b1;
					end
					state_q <= ST_ROUND;
				end
				ST_LEN: begin
					len_pend_q <= 1'b0;
					last_q     <= 1'b1;
					state_q    <= ST_ROUND;
				end
				ST_ROUND: begin
					if (round_q == LAST_ROUND) begin
						round_q <= '0;
						state_q <= ST_ADD;
					end else begin
						round_q <= round_q + 7'd1;
					end
				end
				ST_ADD: begin
					for (int i = 0; i < 5; i++) begin
						hash_q[i] <= hash_q[i] + vars[i];
					end
					if (last_q) begin
						out_idx_q <= '0;
						state_q   <= ST_OUT;
					end else if (len_pend_q) begin
						state_q <= ST_LEN;
					end else if (end_pend_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (rsp.ready) begin
						if (out_idx_q == LAST_WORD) begin
							hash_q   <= H_INIT;
							fill_q   <= '0;
							bitlen_q <= '0;
							last_q   <= 1'b0;
							state_q  <= ST_IDLE;
						end else begin
							out_idx_q <= out_idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
